// ===== hw/rtl/leb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package leb_pkg;

    // Stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    // Operation codes
    localparam logic [1:0] OP_CHAR = 2'd0;
    localparam logic [1:0] OP_KEY  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // Control characters that a character event ignores
    localparam logic [15:0] CH_NUL = 16'h0000;
    localparam logic [15:0] CH_BS  = 16'h0008;
    localparam logic [15:0] CH_TAB = 16'h0009;
    localparam logic [15:0] CH_LF  = 16'h000A;
    localparam logic [15:0] CH_CR  = 16'h000D;
    localparam logic [15:0] CH_ESC = 16'h001B;

    // Virtual-key codes
    localparam logic [15:0] KEY_BACK   = 16'h0008;
    localparam logic [15:0] KEY_END    = 16'h0023;
    localparam logic [15:0] KEY_HOME   = 16'h0024;
    localparam logic [15:0] KEY_LEFT   = 16'h0025;
    localparam logic [15:0] KEY_RIGHT  = 16'h0027;
    localparam logic [15:0] KEY_INSERT = 16'h002D;
    localparam logic [15:0] KEY_DELETE = 16'h002E;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_INSERT,
        ACT_OVERWRITE,
        ACT_LEFT,
        ACT_RIGHT,
        ACT_HOME,
        ACT_END,
        ACT_TOGGLE,
        ACT_DELETE,
        ACT_BACK,
        ACT_READ
    } action_t;

    typedef struct packed {
        logic accept;      // item taken this cycle
        logic exec;        // set up the shift
        logic shift_step;  // one move of the tail
        logic final_step;  // last write and register update
        logic load_out;    // result into the output register
    } dp_cmd_t;

    typedef struct packed {
        logic shift_needed;
        logic shift_last;
        logic out_free;
    } dp_status_t;

    // What an item does, given the editor state flags
    function automatic action_t decode_action(
        input logic [1:0]  op,
        input logic [15:0] code,
        input logic        caret_last,
        input logic        caret_zero,
        input logic        caret_lt_count,
        input logic        ow
    );
        action_t act;
        act = ACT_NONE;
        unique case (op)
            OP_CHAR: begin
                case (code) inside
                    CH_NUL, CH_BS, CH_TAB, CH_LF, CH_CR, CH_ESC: act = ACT_NONE;
                    default: begin
                        if (caret_last) begin
                            act = ACT_NONE;
                        end else begin
                            act = ow ? ACT_OVERWRITE : ACT_INSERT;
                        end
                    end
                endcase
            end
            OP_KEY: begin
                unique case (code)
                    KEY_LEFT:   act = caret_zero ? ACT_NONE : ACT_LEFT;
                    KEY_RIGHT:  act = caret_lt_count ? ACT_RIGHT : ACT_NONE;
                    KEY_HOME:   act = ACT_HOME;
                    KEY_END:    act = ACT_END;
                    KEY_INSERT: act = ACT_TOGGLE;
                    KEY_DELETE: act = caret_lt_count ? ACT_DELETE : ACT_NONE;
                    KEY_BACK:   act = caret_zero ? ACT_NONE : ACT_BACK;
                    default:    act = ACT_NONE;
                endcase
            end
            OP_READ: act = ACT_READ;
            default: act = ACT_NONE;
        endcase
        return act;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/line_editor_buffer.sv =====
// Single-line text editor with insert and overwrite modes.
// s_ channel: one transaction per operation; s_tdata carries operation, code and
//   read_index. Character events insert or overwrite at the caret, key events move
//   the caret, toggle the mode or delete, a read returns one stored character.
// m_ channel: exactly one transaction per input, carrying caret, line_length,
//   overwrite_on and read_char (zero unless the operation was a read).
// Sequence: after acceptance the item is set up, an insert or delete that moves
//   k characters shifts the tail, then the final write and the result follow.
// Throughput: one operation at a time; s_tready rises again as the result enters
//   the output register, so no new operation is taken before the last one's result.
//   k is at most LINE_LEN - 2: the line store has one write port and the tail moves
//   one character per cycle through it.
// Reset (aresetn low, synchronous): caret, length and mode clear, the output
//   register empties. The line store is not cleared; entries at or beyond the
//   length are meaningless.
// Receiver stall: the result waits in the output register; the block holds the
//   next item's result until the register frees and accepts nothing further.
`timescale 1ns / 1ps
`default_nettype none

module line_editor_buffer
    import leb_pkg::*;
#(
    parameter int LINE_LEN = 1024
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [1:0] operation, [17:2] code, [27:18] read_index
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [9:0] caret, [19:10] line_length, [20] overwrite_on, [36:21] read_char
    output logic      [M_TDATA_W-1:0] m_tdata
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: accept, set up, shift, final write, result
    leb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // line store, caret and length registers, output register
    leb_dp #(
        .LINE_LEN (LINE_LEN)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/leb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module leb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/leb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module leb_ctrl
    import leb_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SHIFT,
        ST_DRAIN,
        ST_FINAL,
        ST_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid && ready_reg) state_next = ST_EXEC;
            ST_EXEC:   state_next = status.shift_needed ? ST_SHIFT : ST_FINAL;
            ST_SHIFT:  if (status.shift_last) state_next = ST_DRAIN;
            ST_DRAIN:  state_next = ST_FINAL;
            ST_FINAL:  state_next = ST_RESULT;
            ST_RESULT: if (status.out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_tready = ready_reg;

    always_comb begin
        cmd.accept     = (state_reg == ST_IDLE) && s_tvalid && ready_reg;
        cmd.exec       = (state_reg == ST_EXEC);
        cmd.shift_step = (state_reg == ST_SHIFT);
        cmd.final_step = (state_reg == ST_FINAL);
        cmd.load_out   = (state_reg == ST_RESULT) && status.out_free;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/leb_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module leb_dp
    import leb_pkg::*;
#(
    parameter int LINE_LEN = 1024
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic      [M_TDATA_W-1:0] m_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire dp_cmd_t              cmd,
    output dp_status_t                status
);

    localparam int AW = $clog2(LINE_LEN);
    localparam logic [AW-1:0] LAST   = AW'(LINE_LEN - 1);
    localparam logic [AW-1:0] TOPMAX = AW'(LINE_LEN - 2);
    localparam logic [AW-1:0] ONE    = AW'(1);

    // latched item
    logic [1:0]  op_reg;
    logic [15:0] code_reg;
    logic [9:0]  idx_reg;

    // editor state
    logic [AW-1:0] caret_reg, count_reg;
    logic          ow_reg;

    // shift engine: read one place, then write it once the read data is registered
    logic [AW-1:0] ptr_reg, end_reg, waddr_reg;
    logic          down_reg, wpend_reg;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    action_t       action;
    logic [AW-1:0] top, del_pos, idx_addr;
    logic          idx_ok;
    logic [15:0]   read_char;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [15:0]   ram_wdata, ram_rdata;

    assign action = decode_action(op_reg, code_reg, caret_reg >= LAST, caret_reg == '0,
                                  caret_reg < count_reg, ow_reg);

    // insert moves entries top-1 .. caret up by one
    assign top      = (count_reg > TOPMAX) ? TOPMAX : count_reg;
    assign del_pos  = (action == ACT_BACK) ? caret_reg - ONE : caret_reg;
    assign idx_addr = AW'(idx_reg);
    assign idx_ok   = 32'(idx_reg) < 32'(LINE_LEN);

    always_comb begin
        status.shift_needed = 1'b0;
        if (action == ACT_INSERT) begin
            status.shift_needed = (top != caret_reg);
        end else if (action == ACT_DELETE || action == ACT_BACK) begin
            status.shift_needed = (del_pos + ONE != count_reg);
        end
        status.shift_last = (ptr_reg == end_reg);
        status.out_free   = !m_tvalid_reg || m_tready;
    end

    // RAM ports
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = waddr_reg;
        ram_wdata = ram_rdata;
        if (wpend_reg) begin
            ram_we = 1'b1;
        end else if (cmd.final_step) begin
            if (action == ACT_INSERT || action == ACT_OVERWRITE) begin
                ram_we    = 1'b1;
                ram_waddr = caret_reg;
                ram_wdata = code_reg;
            end else if (action == ACT_DELETE || action == ACT_BACK) begin
                ram_we    = 1'b1;
                ram_waddr = count_reg - ONE;
                ram_wdata = '0;
            end
        end
        ram_raddr = cmd.shift_step ? ptr_reg : idx_addr;
    end

    leb_ram #(
        .WIDTH (16),
        .DEPTH (LINE_LEN)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg   <= s_tdata[1:0];
            code_reg <= s_tdata[17:2];
            idx_reg  <= s_tdata[27:18];
        end
        if (cmd.exec) begin
            if (action == ACT_INSERT) begin
                ptr_reg  <= top - ONE;
                end_reg  <= caret_reg;
                down_reg <= 1'b1;
            end else begin
                ptr_reg  <= del_pos + ONE;
                end_reg  <= count_reg - ONE;
                down_reg <= 1'b0;
            end
        end else if (cmd.shift_step) begin
            ptr_reg   <= down_reg ? ptr_reg - ONE : ptr_reg + ONE;
            waddr_reg <= down_reg ? ptr_reg + ONE : ptr_reg - ONE;
        end
        if (cmd.load_out) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            caret_reg    <= '0;
            count_reg    <= '0;
            ow_reg       <= 1'b0;
            wpend_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            wpend_reg <= cmd.shift_step;
            if (cmd.final_step) begin
                case (action)
                    ACT_INSERT: begin
                        if (count_reg < LAST) count_reg <= count_reg + ONE;
                        caret_reg <= caret_reg + ONE;
                    end
                    ACT_OVERWRITE: begin
                        if (caret_reg >= count_reg) count_reg <= caret_reg + ONE;
                        caret_reg <= caret_reg + ONE;
                    end
                    ACT_LEFT:   caret_reg <= caret_reg - ONE;
                    ACT_RIGHT:  caret_reg <= caret_reg + ONE;
                    ACT_HOME:   caret_reg <= '0;
                    ACT_END:    caret_reg <= count_reg;
                    ACT_TOGGLE: ow_reg <= ~ow_reg;
                    ACT_DELETE: count_reg <= count_reg - ONE;
                    ACT_BACK: begin
                        count_reg <= count_reg - ONE;
                        caret_reg <= caret_reg - ONE;
                    end
                    default: ;
                endcase
            end
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign read_char    = (action == ACT_READ && idx_ok) ? ram_rdata : 16'h0000;
    assign m_tdata_next = {3'b000, read_char, ow_reg, 10'(count_reg), 10'(caret_reg)};

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assert property (@(posedge aclk) disable iff (!aresetn) caret_reg <= count_reg)
        else $error("caret beyond end of line");

    assert property (@(posedge aclk) disable iff (!aresetn) count_reg <= LAST)
        else $error("line length above capacity");

    assert property (@(posedge aclk) disable iff (!aresetn) !(cmd.final_step && wpend_reg))
        else $error("shift write still pending at final step");

    assert property (@(posedge aclk) disable iff (!aresetn)
                     cmd.shift_step && !down_reg |-> ptr_reg < count_reg)
        else $error("delete shift reads past end of line");

endmodule

`default_nettype wire
